@@ rtl/core/kpd_pkg.sv @@
// Package for the keypad scan decode and debounce block.
// Holds key codes, debounce constants and the structs passed between modules.
// No dependencies.
package kpd_pkg;

   // Debounce counter
   localparam int COUNT_W = 3;
   localparam logic [COUNT_W-1:0] PUBLISH_STEP = 3'd3;

   // Key codes
   localparam int KEY_W = 8;
   localparam logic [KEY_W-1:0] KEY_NONE       = 8'h00;
   localparam logic [KEY_W-1:0] KEY_EXTRA_HIGH = 8'h88;
   localparam logic [KEY_W-1:0] KEY_EXTRA_LOW  = 8'hAA;

   // Scan geometry
   localparam int COLS = 3;
   localparam int ROWS = 3;
   localparam int ROW_IDX_W = 2;

   // Result of one row lane
   typedef struct packed {
      logic             hit;
      logic [KEY_W-1:0] code;
   } lane_result_type;

   // Debounce status seen by the top level
   typedef struct packed {
      logic [COUNT_W-1:0] count;
   } dbnc_status_type;

endpackage

@@ rtl/core/kpd_lane.sv @@
// One row lane: checks the row's column bits for a single pressed key
// and forms the grid code. Depends on kpd_pkg.
module kpd_lane (
   input  logic [kpd_pkg::ROW_IDX_W-1:0] row_index,
   input  logic [kpd_pkg::COLS-1:0]      columns,
   output kpd_pkg::lane_result_type      result
);
   import kpd_pkg::*;

   logic [3:0] col_code;

   // One-hot column detect, code nibble is column + 1
   always_comb begin
      unique case (columns)
         3'b001:  col_code = 4'd1;
         3'b010:  col_code = 4'd2;
         3'b100:  col_code = 4'd3;
         default: col_code = 4'd0;
      endcase
   end

   assign result.hit  = (col_code != 4'd0);
   assign result.code = {({2'b00, row_index} + 4'd1), col_code};

endmodule

@@ rtl/core/kpd_merge.sv @@
// Merging stage: combines the row lanes and the two extra key lines into
// one scan candidate. Depends on kpd_pkg.
module kpd_merge (
   input  kpd_pkg::lane_result_type lane0,
   input  kpd_pkg::lane_result_type lane1,
   input  kpd_pkg::lane_result_type lane2,
   input  logic                     extra_key_high,
   input  logic                     extra_key_low,
   output logic [kpd_pkg::KEY_W-1:0] candidate
);
   import kpd_pkg::*;

   logic       low_hit;
   logic [2:0] hit_count;
   logic [KEY_W-1:0] code;

   assign low_hit = ~extra_key_low;

   // Count matching lines
   assign hit_count = {2'b00, lane0.hit} + {2'b00, lane1.hit} + {2'b00, lane2.hit}
                    + {2'b00, extra_key_high} + {2'b00, low_hit};

   // Last matching line wins; only used when exactly one matches
   always_comb begin
      code = KEY_NONE;
      if (lane0.hit)      code = lane0.code;
      if (lane1.hit)      code = lane1.code;
      if (lane2.hit)      code = lane2.code;
      if (extra_key_high) code = KEY_EXTRA_HIGH;
      if (low_hit)        code = KEY_EXTRA_LOW;
   end

   assign candidate = (hit_count == 3'd1) ? code : KEY_NONE;

endmodule

@@ rtl/core/kpd_debounce.sv @@
// Debounce state: latches a candidate, checks agreeing samples and
// publishes the key code. Depends on kpd_pkg.
module kpd_debounce (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  logic [kpd_pkg::KEY_W-1:0] candidate,
   output logic [kpd_pkg::KEY_W-1:0] key_value_in,
   output logic                      key_updated_in,
   output kpd_pkg::dbnc_status_type  status
);
   import kpd_pkg::*;

   logic [KEY_W-1:0]   published_ff, published_in;
   logic [KEY_W-1:0]   cand_ff, cand_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] count_eff;

   // Next-state for one sample
   always_comb begin
      count_eff      = (count_ff > PUBLISH_STEP) ? '0 : count_ff;
      published_in   = published_ff;
      cand_in        = cand_ff;
      count_in       = count_eff;
      key_updated_in = 1'b0;
      priority if (count_eff == '0) begin
         cand_in  = candidate;
         count_in = COUNT_W'(1);
      end else if (count_eff == PUBLISH_STEP) begin
         published_in   = cand_ff;
         count_in       = '0;
         key_updated_in = 1'b1;
      end else if (cand_ff != candidate) begin
         cand_in  = KEY_NONE;
         count_in = '0;
      end else begin
         count_in = count_eff + COUNT_W'(1);
      end
   end

   assign key_value_in = published_in;
   assign status.count = count_ff;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         published_ff <= KEY_NONE;
         cand_ff      <= KEY_NONE;
         count_ff     <= '0;
      end else if (step_en) begin
         published_ff <= published_in;
         cand_ff      <= cand_in;
         count_ff     <= count_in;
      end
   end

endmodule

@@ rtl/core/keypad_scan_decode_debounce.sv @@
// Keypad scan decode and debounce, top level.
// An accepted scan word passes the decode stage register, then the debounce
// state and output register, to the result word. Throughput: one word per
// cycle while rsp_ready does not stall the output register.
// Reset (synchronous, active high) empties the pipeline and clears the
// published key, candidate and agree count to zero.
module keypad_scan_decode_debounce (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_row0_columns,
   input  logic [2:0] req_row1_columns,
   input  logic [2:0] req_row2_columns,
   input  logic       req_extra_key_high,
   input  logic       req_extra_key_low,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_key_value,
   output logic       rsp_key_updated
);
   import kpd_pkg::*;

   lane_result_type lane0, lane1, lane2;
   logic [KEY_W-1:0] candidate;
   logic [KEY_W-1:0] cand_ff;
   logic             dec_valid_ff;
   logic             out_valid_ff;
   logic [KEY_W-1:0] key_value_ff, key_value_in;
   logic             key_updated_ff, key_updated_in;
   logic             out_free, dec_free, load_out;
   dbnc_status_type  status;

   // Row lanes
   kpd_lane u_lane0 (.row_index(2'd0), .columns(req_row0_columns), .result(lane0));
   kpd_lane u_lane1 (.row_index(2'd1), .columns(req_row1_columns), .result(lane1));
   kpd_lane u_lane2 (.row_index(2'd2), .columns(req_row2_columns), .result(lane2));

   // Merge lanes and extra lines
   kpd_merge u_merge (
      .lane0          (lane0),
      .lane1          (lane1),
      .lane2          (lane2),
      .extra_key_high (req_extra_key_high),
      .extra_key_low  (req_extra_key_low),
      .candidate      (candidate)
   );

   // Pipeline flow control
   assign out_free  = ~out_valid_ff | rsp_ready;
   assign load_out  = dec_valid_ff & out_free;
   assign dec_free  = ~dec_valid_ff | out_free;
   assign req_ready = dec_free;

   // Decode stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else if (dec_free) begin
         dec_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (dec_free && req_valid) begin
         cand_ff <= candidate;
      end
   end

   // Debounce state
   kpd_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .step_en        (load_out),
      .candidate      (cand_ff),
      .key_value_in   (key_value_in),
      .key_updated_in (key_updated_in),
      .status         (status)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= dec_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         key_value_ff   <= key_value_in;
         key_updated_ff <= key_updated_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_key_value   = key_value_ff;
   assign rsp_key_updated = key_updated_ff;

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      status.count <= PUBLISH_STEP)
      else $error("agree count out of range");

   a_publish_flag: assert property (@(posedge clock) disable iff (reset)
      load_out && (status.count == PUBLISH_STEP) |=> rsp_valid && rsp_key_updated)
      else $error("publishing step did not flag update");

   a_no_flag: assert property (@(posedge clock) disable iff (reset)
      load_out && (status.count != PUBLISH_STEP) |=> !rsp_key_updated)
      else $error("update flagged on non-publishing step");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !dec_valid_ff |-> req_ready)
      else $error("input stalled with empty decode stage");

endmodule

@@ test/keypad_scan_decode_debounce_tb.sv @@
// Testbench for keypad_scan_decode_debounce: drives scan words, predicts each
// published key word and checks every result word in order.
// Depends on kpd_pkg and the keypad_scan_decode_debounce RTL.
`timescale 1ns / 100ps

module keypad_scan_decode_debounce_tb;
   import kpd_pkg::*;

   localparam int CLOCK_HALF  = 5;
   localparam int RESET_CYCLES = 6;
   localparam int CYCLE_LIMIT = 100000;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_MAX  = 10;
   localparam int ROW_STEP    = 16;
   // key indexes: 0..8 grid (row-major), then the extras and "nothing pressed"
   localparam int KEY_IDX_EXTRA_HIGH = 9;
   localparam int KEY_IDX_EXTRA_LOW  = 10;
   localparam int KEY_IDX_NONE       = 11;

   typedef struct packed {
      logic [ROWS-1:0][COLS-1:0] rows;
      logic                      extra_high;
      logic                      extra_low;
   } scan_word_type;

   typedef struct packed {
      logic [KEY_W-1:0] key_value;
      logic             key_updated;
   } key_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_row0_columns = '0;
   logic [2:0] req_row1_columns = '0;
   logic [2:0] req_row2_columns = '0;
   logic       req_extra_key_high = 1'b0;
   logic       req_extra_key_low = 1'b1;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_key_value;
   logic       rsp_key_updated;

   // predictor state
   logic [KEY_W-1:0]   pred_published = KEY_NONE;
   logic [KEY_W-1:0]   pred_candidate = KEY_NONE;
   logic [COUNT_W-1:0] pred_agree = '0;

   key_word_type expected_keys[$];
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_idle_pct = 0;

   keypad_scan_decode_debounce u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_row0_columns   (req_row0_columns),
      .req_row1_columns   (req_row1_columns),
      .req_row2_columns   (req_row2_columns),
      .req_extra_key_high (req_extra_key_high),
      .req_extra_key_low  (req_extra_key_low),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_key_value      (rsp_key_value),
      .rsp_key_updated    (rsp_key_updated)
   );

   always #CLOCK_HALF clock = ~clock;

   // Key code of one scan: exactly one matching line, else none
   function automatic logic [KEY_W-1:0] decode_scan_code(scan_word_type scan);
      int unsigned      hits;
      logic [KEY_W-1:0] code;
      hits = 0;
      code = KEY_NONE;
      for (int r = 0; r < ROWS; r++) begin
         if ($onehot(scan.rows[r])) begin
            hits++;
            for (int c = 0; c < COLS; c++)
               if (scan.rows[r][c]) code = KEY_W'(ROW_STEP * (r + 1) + c + 1);
         end
      end
      if (scan.extra_high) begin
         hits++;
         code = KEY_EXTRA_HIGH;
      end
      if (!scan.extra_low) begin
         hits++;
         code = KEY_EXTRA_LOW;
      end
      return (hits == 1) ? code : KEY_NONE;
   endfunction

   // Debounce update; returns the published key word for this scan
   function automatic key_word_type debounce_key(logic [KEY_W-1:0] code);
      key_word_type word;
      word.key_updated = 1'b0;
      if (pred_agree > PUBLISH_STEP) pred_agree = '0;
      if (pred_agree == '0) begin
         pred_candidate = code;
         pred_agree = COUNT_W'(1);
      end else if (pred_agree == PUBLISH_STEP) begin
         pred_published = pred_candidate;
         pred_agree = '0;
         word.key_updated = 1'b1;
      end else if (pred_candidate != code) begin
         pred_candidate = KEY_NONE;
         pred_agree = '0;
      end else begin
         pred_agree = pred_agree + 1'b1;
      end
      word.key_value = pred_published;
      return word;
   endfunction

   // Clean scan of one key index
   function automatic scan_word_type key_scan(int unsigned idx);
      scan_word_type scan;
      scan = '{rows: '0, extra_high: 1'b0, extra_low: 1'b1};
      if (idx < ROWS * COLS) scan.rows[idx / COLS][idx % COLS] = 1'b1;
      else if (idx == KEY_IDX_EXTRA_HIGH) scan.extra_high = 1'b1;
      else if (idx == KEY_IDX_EXTRA_LOW) scan.extra_low = 1'b0;
      return scan;
   endfunction

   function automatic scan_word_type noise_scan();
      scan_word_type scan;
      scan = $bits(scan_word_type)'($urandom);
      return scan;
   endfunction

   // Send one scan word; each cycle ahead of it idles with the sender's odds
   task automatic send_scan(input scan_word_type scan);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_row0_columns   <= scan.rows[0];
      req_row1_columns   <= scan.rows[1];
      req_row2_columns   <= scan.rows[2];
      req_extra_key_high <= scan.extra_high;
      req_extra_key_low  <= scan.extra_low;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // Predict on every accepted scan word
   always @(posedge clock) begin
      scan_word_type scan;
      if (!reset && req_valid && req_ready) begin
         scan.rows[0]    = req_row0_columns;
         scan.rows[1]    = req_row1_columns;
         scan.rows[2]    = req_row2_columns;
         scan.extra_high = req_extra_key_high;
         scan.extra_low  = req_extra_key_low;
         expected_keys.push_back(debounce_key(decode_scan_code(scan)));
      end
   end

   // Receiver stalls
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each result word with the oldest prediction
   always @(posedge clock) begin
      key_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_keys.size() == 0) begin
            note_mismatch($sformatf("unexpected word key_value=%0h key_updated=%0b",
                                    rsp_key_value, rsp_key_updated));
         end else begin
            want = expected_keys.pop_front();
            if (rsp_key_value !== want.key_value)
               note_mismatch($sformatf("key_value expected %0h got %0h",
                                       want.key_value, rsp_key_value));
            if (rsp_key_updated !== want.key_updated)
               note_mismatch($sformatf("key_updated expected %0b got %0b",
                                       want.key_updated, rsp_key_updated));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("keypad_scan_decode_debounce test failed");
         $finish;
      end
   end

   // Every grid key, both extras and an empty scan
   task automatic test_single_keys();
      for (int unsigned idx = 0; idx <= KEY_IDX_NONE; idx++) send_scan(key_scan(idx));
   endtask

   // Rows with several bits, several matching lines, all fields at max
   task automatic test_invalid_scans();
      scan_word_type scan;
      scan = key_scan(KEY_IDX_NONE);
      scan.rows[0] = 3'b011;
      send_scan(scan);
      scan.rows[0] = 3'b000;
      scan.rows[1] = 3'b111;
      send_scan(scan);
      scan = key_scan(0);
      scan.rows[2] = 3'b100;
      send_scan(scan);
      scan = key_scan(4);
      scan.extra_high = 1'b1;
      send_scan(scan);
      scan = key_scan(KEY_IDX_EXTRA_HIGH);
      scan.extra_low = 1'b0;
      send_scan(scan);
      send_scan('{rows: '1, extra_high: 1'b1, extra_low: 1'b1});
   endtask

   // A held key publishes again and again with the same code
   task automatic test_repeated_publish();
      repeat (9) send_scan(key_scan(8));
   endtask

   // Mostly held presses with some bounce, the rest random noise
   task automatic test_random_presses(input int unsigned n_words,
                                      input int unsigned send_pct,
                                      input int unsigned recv_pct);
      int unsigned sent;
      int unsigned idx;
      int unsigned hold;
      sent = 0;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (sent < n_words) begin
         if ($urandom_range(99) < 80) begin
            idx  = $urandom_range(KEY_IDX_NONE);
            hold = $urandom_range(1, 8);
            repeat (hold) begin
               if ($urandom_range(99) < 10) send_scan(noise_scan());
               else send_scan(key_scan(idx));
               sent++;
            end
         end else begin
            repeat ($urandom_range(1, 3)) begin
               send_scan(noise_scan());
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 21;
      recv_idle_pct = 46;
      test_single_keys();
      test_invalid_scans();
      test_repeated_publish();
      test_random_presses(400, 21, 46);
      test_random_presses(400, 46, 21);
      test_random_presses(350, 0, 0);
      req_valid <= 1'b0;
      while (expected_keys.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_keys.size() == 0)
         $display("keypad_scan_decode_debounce test passed");
      else
         $display("keypad_scan_decode_debounce test failed");
      $finish;
   end

endmodule
